// ----- sv/blm_pkg.sv -----
// Shared constants, state codes and fixed-point helpers of the line minimizer.
package blm_pkg;

	localparam int QW = 32;
	localparam int DIV_W = 48;
	localparam logic signed [QW-1:0] Q_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [QW-1:0] Q_MIN = 32'sh8000_0000;
	localparam logic signed [QW-1:0] CGOLD = 32'sd25033;

	localparam logic [1:0] ST_EVAL  = 2'd0;
	localparam logic [1:0] ST_FOUND = 2'd1;
	localparam logic [1:0] ST_LIMIT = 2'd2;

	localparam logic [1:0] PH_IDLE  = 2'd0;
	localparam logic [1:0] PH_FIRST = 2'd1;
	localparam logic [1:0] PH_EVAL  = 2'd2;

	localparam logic REG_TOL = 1'b0;
	localparam logic REG_MAX = 1'b1;

	function automatic logic signed [QW-1:0] sat66(input logic signed [65:0] v);
		logic signed [QW-1:0] r;
		if (v > 66'(Q_MAX))
			r = Q_MAX;
		else if (v < 66'(Q_MIN))
			r = Q_MIN;
		else
			r = v[QW-1:0];
		return r;
	endfunction

	function automatic logic signed [QW-1:0] qadd(input logic signed [QW-1:0] a,
			input logic signed [QW-1:0] b);
		return sat66(66'(a) + 66'(b));
	endfunction

	function automatic logic signed [QW-1:0] qsub(input logic signed [QW-1:0] a,
			input logic signed [QW-1:0] b);
		return sat66(66'(a) - 66'(b));
	endfunction

	// Product in Q32.32, shifted back with rounding toward minus infinity.
	function automatic logic signed [QW-1:0] qscale(input logic signed [65:0] p);
		return sat66(p >>> 16);
	endfunction

endpackage

// ----- sv/blm_mul.sv -----
// Shared signed multiplier with registered product.
module blm_mul import blm_pkg::*; (
	input  logic               clk,
	input  logic signed [32:0] op_a,
	input  logic signed [32:0] op_b,
	output logic signed [65:0] prod
);

	logic signed [65:0] prod_q;

	always_ff @(posedge clk) begin
		prod_q <= 66'(op_a) * 66'(op_b);
	end

	assign prod = prod_q;

endmodule

// ----- sv/blm_div.sv -----
// Restoring divider, one quotient bit per cycle, for the parabolic step.
module blm_div import blm_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DIV_W-1:0] dividend,
	input  logic [QW-1:0]    divisor,
	output logic             done,
	output logic [DIV_W-1:0] quotient
);

	logic [DIV_W-1:0] num_q;
	logic [QW-1:0]    rem_q;
	logic [QW-1:0]    dv_q;
	logic [5:0]       cnt_q;
	logic             done_q;
	logic [QW-1:0]    trial;
	logic             take;

	assign trial = {rem_q[QW-2:0], num_q[DIV_W-1]};
	assign take  = (trial >= dv_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= 6'(DIV_W);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1)
					done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			rem_q <= '0;
			dv_q  <= divisor;
		end else if (cnt_q != '0) begin
			rem_q <= take ? trial - dv_q : trial;
			num_q <= {num_q[DIV_W-2:0], take};
		end
	end

	assign done     = done_q;
	assign quotient = num_q;

endmodule

// ----- sv/brent_line_minimizer.sv -----
// Top level: Brent line minimizer with the objective evaluated outside.
//
// Requests arrive on the s_ side. s_tuser = 0 starts a search with the bracket in
// s_tdata; the block answers with status 0 and the middle point to evaluate.
// s_tuser = 1 returns the objective value at the last requested point; the block
// answers with the next point (status 0), the minimum (status 1) or the limit
// error (status 2). A value request while no search runs gives no answer.
// Results leave on the m_ side from one output register.
// A start answers in the cycle after acceptance. A value request runs a small
// sequencer around one shared multiplier: it checks the evaluation limit, then
// convergence, and then takes a golden-section step or tries a parabolic step,
// which falls back to golden section when rejected and when accepted waits on the
// bit-serial divider. The block takes one request at a time: s_tready stays low
// while the sequencer works and while a result waits in the output register, and
// rises in the cycle after that result is taken, so a stalled receiver holds back
// the next request.
// Reset clears the search state, sets rel_tolerance to 13 and max_evaluations to
// 100. Configuration writes take effect at once and belong between searches.
module brent_line_minimizer import blm_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [127:0] s_tdata,  // bracket_a, bracket_mid, bracket_c, objective_value
	input  logic         s_tuser,  // func
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [63:0]  m_tdata,  // point, best_value
	output logic [1:0]   m_tuser,  // status
	input  logic         cfg_we,
	input  logic         cfg_index,
	input  logic [15:0]  cfg_data
);

	localparam logic [4:0] S_IDLE = 5'd0;
	localparam logic [4:0] S_IT0  = 5'd1;
	localparam logic [4:0] S_IT1  = 5'd2;
	localparam logic [4:0] S_IT2  = 5'd3;
	localparam logic [4:0] S_P0   = 5'd4;
	localparam logic [4:0] S_P1   = 5'd5;
	localparam logic [4:0] S_P2   = 5'd6;
	localparam logic [4:0] S_P3   = 5'd7;
	localparam logic [4:0] S_P4   = 5'd8;
	localparam logic [4:0] S_P5   = 5'd9;
	localparam logic [4:0] S_P6   = 5'd10;
	localparam logic [4:0] S_P7   = 5'd11;
	localparam logic [4:0] S_P8   = 5'd12;
	localparam logic [4:0] S_DIVW = 5'd13;
	localparam logic [4:0] S_P9   = 5'd14;
	localparam logic [4:0] S_GOLD = 5'd15;
	localparam logic [4:0] S_G1   = 5'd16;
	localparam logic [4:0] S_FIN  = 5'd17;

	logic [4:0]  st_q;
	logic [1:0]  phase_q;
	logic [15:0] rel_tol_q;
	logic [7:0]  max_eval_q;
	logic [7:0]  cnt_q;

	logic signed [QW-1:0] a_q, b_q, x_q, w_q, v_q, fx_q, fw_q, fv_q;
	logic signed [QW-1:0] e_q, d_q, u_q, xm_q, tol1_q, tol2_q;
	logic signed [QW-1:0] r_q, q_q, p_q, etemp_q;
	logic                 c1_q, c2_q;

	logic                 m_valid_q;
	logic [1:0]           m_status_q;
	logic signed [QW-1:0] m_point_q, m_best_q;

	logic signed [32:0] mul_a, mul_b;
	logic signed [65:0] mp;
	logic signed [QW-1:0] qm, gstep;
	logic               div_start, div_done;
	logic [DIV_W-1:0]   div_quo;

	logic signed [QW-1:0] in_a, in_mid, in_c, in_f;
	logic accept;

	assign in_a   = s_tdata[31:0];
	assign in_mid = s_tdata[63:32];
	assign in_c   = s_tdata[95:64];
	assign in_f   = s_tdata[127:96];

	assign s_tready = (st_q == S_IDLE) && !m_valid_q;
	assign accept   = s_tvalid && s_tready;

	assign qm    = qscale(mp);
	assign gstep = (x_q >= xm_q) ? qsub(a_q, x_q) : qsub(b_q, x_q);

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (st_q)
			S_IT0: begin
				mul_a = 33'({1'b0, rel_tol_q});
				mul_b = x_q[QW-1] ? -33'(x_q) : 33'(x_q);
			end
			S_P0: begin
				mul_a = 33'(qsub(x_q, w_q));
				mul_b = 33'(qsub(fx_q, fv_q));
			end
			S_P1: begin
				mul_a = 33'(qsub(x_q, v_q));
				mul_b = 33'(qsub(fx_q, fw_q));
			end
			S_P2: begin
				mul_a = 33'(qsub(x_q, v_q));
				mul_b = 33'(qm);
			end
			S_P3: begin
				mul_a = 33'(qsub(x_q, w_q));
				mul_b = 33'(r_q);
			end
			S_P5: begin
				mul_a = 33'(q_q);
				mul_b = 33'(etemp_q);
			end
			S_P6: begin
				mul_a = 33'(q_q);
				mul_b = 33'(qsub(a_q, x_q));
			end
			S_P7: begin
				mul_a = 33'(q_q);
				mul_b = 33'(qsub(b_q, x_q));
			end
			S_GOLD: begin
				mul_a = 33'(CGOLD);
				mul_b = 33'(gstep);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	blm_mul u_mul (
		.clk  (clk),
		.op_a (mul_a),
		.op_b (mul_b),
		.prod (mp)
	);

	assign div_start = (st_q == S_P8) && !((q_q == '0) || c1_q || c2_q || (p_q >= qm));

	blm_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (DIV_W'(p_q[QW-1] ? -33'(p_q) : 33'(p_q)) << 16),
		.divisor  (q_q),
		.done     (div_done),
		.quotient (div_quo)
	);

	// Combinational helpers for the convergence test and the final steps.
	logic signed [35:0] lim, x_dist;
	logic signed [32:0] xm_sum;
	logic signed [QW-1:0] pt, qq, dsat;
	logic signed [34:0] ut;
	logic signed [32:0] dmag, pmag, hmag;
	logic signed [QW-1:0] half;

	assign xm_sum = 33'(a_q) + 33'(b_q);
	assign lim    = 36'(tol2_q) - 36'((33'(b_q) - 33'(a_q)) >>> 1);
	assign x_dist = (36'(x_q) - 36'(xm_q) < 0) ? 36'(xm_q) - 36'(x_q)
	                                            : 36'(x_q) - 36'(xm_q);
	assign pt     = qsub(p_q, qm);
	assign qq     = sat66(66'(qsub(q_q, r_q)) * 66'sd2);
	assign half   = qm >>> 1;
	assign pmag   = p_q[QW-1] ? -33'(p_q) : 33'(p_q);
	assign hmag   = half[QW-1] ? -33'(half) : 33'(half);
	assign dmag   = d_q[QW-1] ? -33'(d_q) : 33'(d_q);

	always_comb begin
		if (p_q[QW-1])
			dsat = (div_quo > 48'h0000_8000_0000) ? Q_MIN : QW'(-49'(div_quo));
		else
			dsat = (div_quo > 48'h0000_7FFF_FFFF) ? Q_MAX : QW'(div_quo);
	end
	assign ut = 35'(x_q) + 35'(dsat);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q       <= S_IDLE;
			phase_q    <= PH_IDLE;
			rel_tol_q  <= 16'd13;
			max_eval_q <= 8'd100;
			cnt_q      <= '0;
			m_valid_q  <= 1'b0;
			m_status_q <= ST_EVAL;
			m_point_q  <= '0;
			m_best_q   <= '0;
			a_q <= '0; b_q <= '0; x_q <= '0; w_q <= '0; v_q <= '0;
			fx_q <= '0; fw_q <= '0; fv_q <= '0;
			e_q <= '0; d_q <= '0; u_q <= '0;
			xm_q <= '0; tol1_q <= '0; tol2_q <= '0;
			r_q <= '0; q_q <= '0; p_q <= '0; etemp_q <= '0;
			c1_q <= 1'b0; c2_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_TOL: rel_tol_q  <= cfg_data;
					REG_MAX: max_eval_q <= cfg_data[7:0];
					default: ;
				endcase
			end
			if (m_valid_q && m_tready)
				m_valid_q <= 1'b0;

			unique case (st_q)
				S_IDLE: begin
					if (accept) begin
						if (!s_tuser) begin
							a_q <= (in_a < in_c) ? in_a : in_c;
							b_q <= (in_a > in_c) ? in_a : in_c;
							x_q <= in_mid; w_q <= in_mid; v_q <= in_mid;
							fx_q <= '0; fw_q <= '0; fv_q <= '0;
							e_q <= '0; d_q <= '0; u_q <= in_mid;
							cnt_q <= '0;
							phase_q <= PH_FIRST;
							m_valid_q  <= 1'b1;
							m_status_q <= ST_EVAL;
							m_point_q  <= in_mid;
							m_best_q   <= '0;
						end else if (phase_q == PH_FIRST) begin
							fx_q <= in_f; fw_q <= in_f; fv_q <= in_f;
							st_q <= S_IT0;
						end else if (phase_q == PH_EVAL) begin
							if (in_f <= fx_q) begin
								if (u_q >= x_q) a_q <= x_q; else b_q <= x_q;
								v_q <= w_q; w_q <= x_q; x_q <= u_q;
								fv_q <= fw_q; fw_q <= fx_q; fx_q <= in_f;
							end else begin
								if (u_q < x_q) a_q <= u_q; else b_q <= u_q;
								if (in_f <= fw_q || w_q == x_q) begin
									v_q <= w_q; w_q <= u_q;
									fv_q <= fw_q; fw_q <= in_f;
								end else if (in_f <= fv_q || v_q == x_q || v_q == w_q) begin
									v_q <= u_q;
									fv_q <= in_f;
								end
							end
							st_q <= S_IT0;
						end
					end
				end
				S_IT0: begin
					if (cnt_q >= max_eval_q) begin
						phase_q    <= PH_IDLE;
						m_valid_q  <= 1'b1;
						m_status_q <= ST_LIMIT;
						m_point_q  <= x_q;
						m_best_q   <= fx_q;
						st_q       <= S_IDLE;
					end else begin
						xm_q <= xm_sum[32:1];
						st_q <= S_IT1;
					end
				end
				S_IT1: begin
					tol1_q <= sat66((mp >>> 16) + 66'sd1);
					tol2_q <= sat66(((mp >>> 16) + 66'sd1) * 66'sd2);
					st_q   <= S_IT2;
				end
				S_IT2: begin
					if (x_dist <= lim) begin
						phase_q    <= PH_IDLE;
						m_valid_q  <= 1'b1;
						m_status_q <= ST_FOUND;
						m_point_q  <= x_q;
						m_best_q   <= fx_q;
						st_q       <= S_IDLE;
					end else if ((e_q[QW-1] ? -33'(e_q) : 33'(e_q)) > 33'(tol1_q)) begin
						st_q <= S_P0;
					end else begin
						st_q <= S_GOLD;
					end
				end
				S_P0: st_q <= S_P1;
				S_P1: begin
					r_q  <= qm;
					st_q <= S_P2;
				end
				S_P2: begin
					q_q  <= qm;
					st_q <= S_P3;
				end
				S_P3: begin
					p_q  <= qm;
					st_q <= S_P4;
				end
				S_P4: begin
					p_q     <= (qq > 0) ? sat66(-66'(pt)) : pt;
					q_q     <= qq[QW-1] ? sat66(-66'(qq)) : qq;
					etemp_q <= e_q;
					e_q     <= d_q;
					st_q    <= S_P5;
				end
				S_P5: st_q <= S_P6;
				S_P6: begin
					c1_q <= (pmag >= hmag);
					st_q <= S_P7;
				end
				S_P7: begin
					c2_q <= (p_q <= qm);
					st_q <= S_P8;
				end
				S_P8: begin
					st_q <= div_start ? S_DIVW : S_GOLD;
				end
				S_DIVW: begin
					if (div_done)
						st_q <= S_P9;
				end
				S_P9: begin
					if (ut - 35'(a_q) < 35'(tol2_q) || 35'(b_q) - ut < 35'(tol2_q))
						d_q <= (xm_q > x_q) ? tol1_q : -tol1_q;
					else
						d_q <= dsat;
					st_q <= S_FIN;
				end
				S_GOLD: begin
					e_q  <= gstep;
					st_q <= S_G1;
				end
				S_G1: begin
					d_q  <= qm;
					st_q <= S_FIN;
				end
				S_FIN: begin
					logic signed [QW-1:0] nu;
					if (dmag >= 33'(tol1_q))
						nu = qadd(x_q, d_q);
					else
						nu = qadd(x_q, (d_q > 0) ? tol1_q : -tol1_q);
					u_q        <= nu;
					cnt_q      <= cnt_q + 8'd1;
					phase_q    <= PH_EVAL;
					m_valid_q  <= 1'b1;
					m_status_q <= ST_EVAL;
					m_point_q  <= nu;
					m_best_q   <= '0;
					st_q       <= S_IDLE;
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tuser  = m_status_q;
	assign m_tdata  = {m_best_q, m_point_q};

endmodule

// ----- bench/tb_brent_line_minimizer.sv -----
// Self-checking testbench for the Brent line minimizer with an external objective.
module tb_brent_line_minimizer import blm_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam bit FN_START = 1'b0;
	localparam bit FN_VALUE = 1'b1;
	localparam int CYCLE_LIMIT = 1500000;

	typedef struct packed {
		logic [1:0] status;
		logic signed [31:0] point;
		logic signed [31:0] best_value;
	} answer_t;

	typedef struct {
		bit func;
		logic signed [31:0] a, mid, c, f;
		bit typed;
		answer_t ans;
	} row_t;

	logic clk = 0, arst_n = 0;
	logic s_tvalid = 0, s_tuser = 0, m_tready = 0;
	logic [127:0] s_tdata = '0;
	logic s_tready, m_tvalid;
	logic [63:0] m_tdata;
	logic [1:0] m_tuser;
	logic cfg_we = 0, cfg_index = 0;
	logic [15:0] cfg_data = '0;

	brent_line_minimizer dut (.*);

	always #5 clk = ~clk;

	// Predictor state of the search.
	logic [15:0] rtol;
	logic [7:0] max_evals, n_evals;
	logic signed [31:0] lo, hi, bx, wx, vx, bf, wf, vf, e_step, d_step, ux;
	logic [1:0] ph;

	answer_t awaited_answers[$];
	int fails = 0;
	int cycles = 0;
	bit quiet = 0;
	bit hold_long = 0;

	function automatic logic signed [31:0] sat64(longint v);
		if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
		if (v < -64'sd2147483648) return 32'sh8000_0000;
		return v[31:0];
	endfunction
	function automatic longint absl(longint v);
		return v < 0 ? -v : v;
	endfunction
	function automatic logic signed [31:0] fsub(longint a, longint b);
		return sat64(a - b);
	endfunction
	function automatic logic signed [31:0] fmul(longint a, longint b);
		return sat64((a * b) >>> 16);
	endfunction

	function automatic answer_t next_point();
		longint xm, tol1, tol2, lim, r, q, p, etemp, d, u, ut;
		if (n_evals >= max_evals) begin
			ph = PH_IDLE;
			return '{ST_LIMIT, bx, bf};
		end
		xm = (longint'(lo) + hi) >>> 1;
		tol1 = sat64(((longint'(rtol) * absl(bx)) >>> 16) + 1);
		tol2 = sat64(2 * tol1);
		lim = tol2 - ((longint'(hi) - lo) >>> 1);
		if (absl(bx - xm) <= lim) begin
			ph = PH_IDLE;
			return '{ST_FOUND, bx, bf};
		end
		if (absl(e_step) > tol1) begin
			r = fmul(fsub(bx, wx), fsub(bf, vf));
			q = fmul(fsub(bx, vx), fsub(bf, wf));
			p = fsub(fmul(fsub(bx, vx), q), fmul(fsub(bx, wx), r));
			etemp = e_step;
			q = sat64(2 * longint'(fsub(q, r)));
			if (q > 0) p = sat64(-p);
			q = sat64(absl(q));
			e_step = d_step;
			if (q == 0 || absl(p) >= absl(fmul(q, etemp) >>> 1) ||
					p <= fmul(q, fsub(lo, bx)) || p >= fmul(q, fsub(hi, bx))) begin
				e_step = (bx >= xm) ? fsub(lo, bx) : fsub(hi, bx);
				d = fmul(CGOLD, e_step);
			end else begin
				d = sat64((p * 65536) / q);
				ut = bx + d;
				if (ut - lo < tol2 || longint'(hi) - ut < tol2)
					d = (xm > bx) ? tol1 : -tol1;
			end
		end else begin
			e_step = (bx >= xm) ? fsub(lo, bx) : fsub(hi, bx);
			d = fmul(CGOLD, e_step);
		end
		d_step = 32'(d);
		if (absl(d) >= tol1) u = sat64(bx + d);
		else u = sat64(bx + (d > 0 ? tol1 : -tol1));
		ux = 32'(u);
		n_evals = n_evals + 8'd1;
		ph = PH_EVAL;
		return '{ST_EVAL, 32'(u), 32'sd0};
	endfunction

	// Returns 1 and the answer when the request produces one.
	function automatic bit minimizer_step(bit func, logic signed [31:0] a, m, c, f,
			output answer_t ans);
		if (func == FN_START) begin
			lo = a < c ? a : c;
			hi = a > c ? a : c;
			bx = m; wx = m; vx = m;
			bf = 0; wf = 0; vf = 0;
			e_step = 0; d_step = 0; ux = m; n_evals = 0;
			ph = PH_FIRST;
			ans = '{ST_EVAL, m, 32'sd0};
			return 1;
		end
		if (ph == PH_FIRST) begin
			bf = f; wf = f; vf = f;
			ans = next_point();
			return 1;
		end
		if (ph != PH_EVAL) return 0;
		if (f <= bf) begin
			if (ux >= bx) lo = bx; else hi = bx;
			vx = wx; wx = bx; bx = ux;
			vf = wf; wf = bf; bf = f;
		end else begin
			if (ux < bx) lo = ux; else hi = ux;
			if (f <= wf || wx == bx) begin
				vx = wx; wx = ux; vf = wf; wf = f;
			end else if (f <= vf || vx == bx || vx == wx) begin
				vx = ux; vf = f;
			end
		end
		ans = next_point();
		return 1;
	endfunction

	// The request line drops only while idling, so back-to-back requests keep it high.
	task automatic idle_burst();
		if (!quiet && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	// Sends one request and books its expected answer, if it produces one.
	task automatic send(bit func, logic signed [31:0] a, m, c, f,
			bit typed = 0, answer_t typed_ans = '0);
		answer_t ans;
		idle_burst();
		s_tvalid <= 1;
		s_tuser <= func;
		s_tdata <= {f, c, m, a};
		do @(posedge clk); while (!s_tready);
		if (minimizer_step(func, a, m, c, f, ans)) begin
			if (typed && ans !== typed_ans) begin
				$error("typed row disagrees with predictor: %h vs %h", typed_ans, ans);
				fails++;
			end
			awaited_answers.push_back(typed ? typed_ans : ans);
		end
	endtask

	task automatic write_reg(logic idx, logic [15:0] val);
		@(posedge clk);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 0;
		if (idx == REG_TOL) rtol = val;
		else max_evals = val[7:0];
	endtask

	task automatic drain();
		s_tvalid <= 0;
		while (awaited_answers.size() != 0) @(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	// Random objective: a quadratic around a random centre plus noise.
	function automatic logic signed [31:0] objective(logic signed [31:0] x,
			logic signed [31:0] ctr, int curv, int noise);
		longint dx;
		dx = (longint'(x) - ctr) >>> 8;
		return sat64(((dx * dx * curv) >>> 16) +
			$signed($urandom_range(0, 2 * noise)) - noise);
	endfunction

	// One search with random bracket; returns the number of requests made.
	task automatic run_search(output int used);
		logic signed [31:0] a, m, c, ctr;
		int curv, noise, span;
		used = 1;
		span = (1 << $urandom_range(4, 26));
		m = $urandom_range(0, 1) ? $signed($urandom) >>> $urandom_range(1, 12) : 0;
		a = sat64(longint'(m) - $urandom_range(1, span));
		c = sat64(longint'(m) + $urandom_range(1, span));
		if ($urandom_range(0, 1)) {a, c} = {c, a};
		ctr = sat64(longint'(m) + $signed($urandom_range(0, span)) - span / 2);
		curv = $urandom_range(1, 4000);
		noise = $urandom_range(0, 3) == 0 ? $urandom_range(0, 50000) : 0;
		send(FN_START, a, m, c, 0);
		while (ph != PH_IDLE) begin
			if ($urandom_range(0, 40) == 0)
				send(FN_VALUE, 0, 0, 0, $urandom);
			else if ($urandom_range(0, 60) == 0) begin
				send(FN_START, $urandom, $urandom, $urandom, 0);
			end else
				send(FN_VALUE, $urandom, $urandom, $urandom, objective(ux, ctr, curv, noise));
			used++;
		end
	endtask

	// Output side: random stalls, one long hold-off, checking.
	always @(posedge clk) begin
		answer_t want;
		if (m_tvalid && m_tready) begin
			if (awaited_answers.size() == 0) begin
				$error("answer with nothing expected: %h", {m_tuser, m_tdata});
				fails++;
			end else begin
				want = awaited_answers.pop_front();
				if (m_tuser !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, m_tuser);
					fails++;
				end
				if (m_tdata[31:0] !== want.point) begin
					$error("point: expected %h, got %h", want.point, m_tdata[31:0]);
					fails++;
				end
				if (m_tdata[63:32] !== want.best_value) begin
					$error("best_value: expected %h, got %h", want.best_value, m_tdata[63:32]);
					fails++;
				end
			end
		end
	end

	initial begin
		int stall;
		@(posedge arst_n);
		forever begin
			if (hold_long) begin
				m_tready <= 0;
				repeat (300) @(posedge clk);
				hold_long = 0;
			end
			if (!quiet && $urandom_range(0, 4) == 0) begin
				stall = $urandom_range(1, 6);
				m_tready <= 0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1;
			@(posedge clk);
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	row_t rows[$];
	initial begin
		int used, sent;
		logic signed [31:0] rmin, rmax;
		rmin = 32'sh8000_0000;
		rmax = 32'sh7FFF_FFFF;
		rtol = 16'd13; max_evals = 8'd100; ph = PH_IDLE; n_evals = 0;
		lo = 0; hi = 0; bx = 0; wx = 0; vx = 0; bf = 0; wf = 0; vf = 0;
		e_step = 0; d_step = 0; ux = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed: value while idle, starts at the extremes, start while busy.
		rows = '{
			'{FN_VALUE, 0, 0, 0, 32'sd5, 0, '0},
			'{FN_START, rmin, 0, rmax, 0, 1, '{ST_EVAL, 0, 0}},
			'{FN_VALUE, 0, 0, 0, rmax, 0, '0},
			'{FN_VALUE, 0, 0, 0, rmin, 0, '0},
			'{FN_START, rmax, rmin, rmin, 0, 1, '{ST_EVAL, rmin, 0}},
			'{FN_VALUE, 0, 0, 0, 0, 0, '0},
			'{FN_START, -32'sh10000, 32'sh1000, 32'sh20000, 0, 1, '{ST_EVAL, 32'sh1000, 0}},
			'{FN_VALUE, 0, 0, 0, 32'sh40000, 0, '0},
			'{FN_VALUE, 0, 0, 0, 32'sh30000, 0, '0},
			'{FN_VALUE, 0, 0, 0, 32'sh30000, 0, '0},
			'{FN_VALUE, 0, 0, 0, 32'sh20000, 0, '0},
			'{FN_VALUE, 0, 0, 0, 32'sh50000, 0, '0},
			'{FN_START, 32'sd5, 32'sd5, 32'sd5, 0, 1, '{ST_EVAL, 32'sd5, 0}},
			'{FN_VALUE, 0, 0, 0, 32'sd77, 1, '{ST_FOUND, 32'sd5, 32'sd77}},
			'{FN_VALUE, 0, 0, 0, 32'sd1, 0, '0}
		};
		foreach (rows[i])
			send(rows[i].func, rows[i].a, rows[i].mid, rows[i].c, rows[i].f,
				rows[i].typed, rows[i].ans);
		drain();

		// Limit right after the first value, then the widest tolerance, then zero tolerance with a limit of one.
		write_reg(REG_MAX, 16'd0);
		send(FN_START, -32'sh30000, 32'sh100, 32'sh30000, 0);
		send(FN_VALUE, 0, 0, 0, 32'sh1234, 1, '{ST_LIMIT, 32'sh100, 32'sh1234});
		drain();
		write_reg(REG_MAX, 16'd255);
		write_reg(REG_TOL, 16'hFFFF);
		run_search(used);
		drain();
		write_reg(REG_TOL, 16'd0);
		write_reg(REG_MAX, 16'd1);
		run_search(used);
		drain();

		// Random part over several configurations; long hold-off in the first phase.
		sent = 0;
		for (int phs = 0; phs < 6; phs++) begin
			unique case (phs)
				0: begin write_reg(REG_TOL, 16'd13); write_reg(REG_MAX, 16'd100); end
				1: begin write_reg(REG_TOL, 16'd0); write_reg(REG_MAX, 16'd255); end
				2: begin write_reg(REG_TOL, 16'hFFFF); write_reg(REG_MAX, 16'd3); end
				3: begin
					write_reg(REG_TOL, 16'($urandom));
					write_reg(REG_MAX, 16'($urandom_range(1, 255)));
				end
				4: begin write_reg(REG_TOL, 16'd1); write_reg(REG_MAX, 16'd20); end
				default: begin write_reg(REG_TOL, 16'd600); write_reg(REG_MAX, 16'd60); end
			endcase
			if (phs == 5) quiet = 1;
			while (sent < 290 * (phs + 1)) begin
				if (phs == 0 && sent > 40 && sent < 45) hold_long = 1;
				if ($urandom_range(0, 30) == 0) begin
					send(FN_VALUE, $urandom, $urandom, $urandom, $urandom);
					sent++;
				end else begin
					run_search(used);
					sent += used;
				end
			end
			drain();
		end

		if (fails == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

// ----- files.f -----
sv/blm_pkg.sv
sv/blm_mul.sv
sv/blm_div.sv
sv/brent_line_minimizer.sv
bench/tb_brent_line_minimizer.sv
